/* sv/pst_pkg.sv */
// shared constants, types and codes for the priority sum tree
package pst_pkg;

    localparam int LEAF_COUNT    = 1024;
    localparam int PRIORITY_BITS = 32;

    localparam int LEAF_W     = $clog2(LEAF_COUNT);
    localparam int NODE_W     = LEAF_W + 1;
    localparam int SUM_W      = PRIORITY_BITS + LEAF_W;
    localparam int CNT_W      = LEAF_W + 1;
    localparam int LVL_W      = $clog2(LEAF_W + 1);
    localparam int NODE_DEPTH = 2 * LEAF_COUNT;
    localparam int OP_W       = 2;
    localparam int SAMPLE_W   = 42;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int INIT_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT    = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_UPDATE = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_READ   = 2'd2,
        OP_FILL   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_UPD_LEAF,
        S_UPD_ANC,
        S_WALK,
        S_WALK_LEAF,
        S_RD_LEAF,
        S_RESULT
    } st_t;

    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        logic [SUM_W-1:0]  wr_data;
    } ram_req_t;

endpackage

/* sv/pst_node_ram.sv */
// node sum memory: one write port, one registered read port
module pst_node_ram (
    input  logic                     clk,
    input  pst_pkg::ram_req_t        req,
    output logic [pst_pkg::SUM_W-1:0] rd_data
);
    import pst_pkg::*;

    logic [SUM_W-1:0] mem_reg [NODE_DEPTH];
    logic [SUM_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_reg[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem_reg[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/priority_sum_tree.sv */
// priority sum tree top level: sequencer, sweep pipeline and result register
//
//  channel   direction  handshake            payload
//  cfg       in         cfg_we               cfg_index, cfg_data
//  in        in         in_valid / in_stall  opcode, leaf_index, new_priority, sample_value
//  out       out        out_valid / out_stall found_index, found_priority, total_sum, index_error
//
// one request at a time; the node memory port walks one tree level per cycle
// update and sample pass through every tree level, read only the leaf; an out-of-range update or read skips the memory
// fill sweeps every node once through a multiply stage
// after reset the same sweep clears the memory (in_stall high)
// a finished result waits in the output register while the next request is taken
module priority_sum_tree (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pst_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pst_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [pst_pkg::OP_W-1:0]          opcode,
    input  logic [pst_pkg::LEAF_W-1:0]        leaf_index,
    input  logic [pst_pkg::PRIORITY_BITS-1:0] new_priority,
    input  logic [pst_pkg::SAMPLE_W-1:0]      sample_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [pst_pkg::LEAF_W-1:0]        found_index,
    output logic [pst_pkg::PRIORITY_BITS-1:0] found_priority,
    output logic [pst_pkg::SUM_W-1:0]         total_sum,
    output logic                              index_error
);
    import pst_pkg::*;

    st_t state_reg, state_next;
    ram_req_t ram_req;
    logic [SUM_W-1:0] rd_data;

    logic [CNT_W-1:0]  entries_reg;
    logic [INIT_W-1:0] init_prio_reg;
    logic [SUM_W-1:0]  root_reg;

    logic [NODE_W-1:0]        node_reg;
    logic [SUM_W-1:0]         val_reg;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [SUM_W-1:0]         diff_reg;

    logic [LEAF_W-1:0]        res_index_reg;
    logic [PRIORITY_BITS-1:0] res_prio_reg;
    logic                     res_err_reg;

    logic                     out_valid_reg;
    logic [LEAF_W-1:0]        found_index_reg;
    logic [PRIORITY_BITS-1:0] found_priority_reg;
    logic [SUM_W-1:0]         total_sum_reg;
    logic                     index_error_reg;

    // sweep pipeline
    logic [LVL_W-1:0]         lvl_reg;
    logic [LEAF_W-1:0]        off_reg;
    logic                     sweep_done_reg;
    logic                     sweep_result_reg;
    logic [PRIORITY_BITS-1:0] sweep_prio_reg;
    logic                     s1_vld_reg;
    logic [NODE_W-1:0]        s1_node_reg;
    logic [CNT_W-1:0]         s1_count_reg;
    logic                     s2_vld_reg;
    logic [NODE_W-1:0]        s2_node_reg;
    logic [SUM_W-1:0]         s2_sum_reg;

    logic in_accept;
    logic in_ok;
    op_t  op_in;
    logic out_load;

    logic              go_right;
    logic [NODE_W-1:0] walk_next;
    logic [SUM_W-1:0]  val_sub;
    logic [SUM_W-1:0]  upd_sum;

    logic              sweep_issue;
    logic              sweep_last;
    logic              off_last;
    logic [LVL_W-1:0]  shift;
    logic [NODE_W-1:0] sweep_node;
    logic [CNT_W-1:0]  span;
    logic [CNT_W-1:0]  first_leaf;
    logic [CNT_W-1:0]  lim;
    logic [CNT_W-1:0]  remain;
    logic [CNT_W-1:0]  count;
    logic [CNT_W+PRIORITY_BITS-1:0] product;

    pst_node_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    assign in_accept = in_valid && !in_stall;
    assign op_in     = op_t'(opcode);
    assign in_ok     = {1'b0, leaf_index} < entries_reg;
    assign out_load  = (state_reg == S_RESULT) && (!out_valid_reg || !out_stall);

    // descent step: left child sum sits in rd_data
    assign go_right  = val_reg > rd_data;
    assign walk_next = {node_reg[NODE_W-2:0], go_right};
    assign val_sub   = val_reg - rd_data;
    assign upd_sum   = rd_data + diff_reg;

    // node value for fill: leaves below lim in this node's span times the priority
    always_comb
    begin
        shift      = LVL_W'(LEAF_W) - lvl_reg;
        sweep_node = (NODE_W'(1) << lvl_reg) | NODE_W'(off_reg);
        span       = CNT_W'(1) << shift;
        first_leaf = CNT_W'(off_reg) << shift;
        lim        = (entries_reg > CNT_W'(LEAF_COUNT)) ? CNT_W'(LEAF_COUNT) : entries_reg;
        remain     = lim - first_leaf;
        if (lim <= first_leaf)
        begin
            count = '0;
        end
        else if (remain > span)
        begin
            count = span;
        end
        else
        begin
            count = remain;
        end
        off_last    = (NODE_W'(off_reg) == ((NODE_W'(1) << lvl_reg) - NODE_W'(1)));
        sweep_last  = (lvl_reg == LVL_W'(LEAF_W)) && (&off_reg);
        sweep_issue = (state_reg == S_SWEEP) && !sweep_done_reg;
        product     = s1_count_reg * sweep_prio_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_SWEEP:
            begin
                if (sweep_done_reg && !s1_vld_reg && !s2_vld_reg)
                begin
                    state_next = sweep_result_reg ? S_RESULT : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (op_in)
                        OP_UPDATE: state_next = in_ok ? S_UPD_LEAF : S_RESULT;
                        OP_SAMPLE: state_next = S_WALK;
                        OP_READ:   state_next = in_ok ? S_RD_LEAF : S_RESULT;
                        OP_FILL:   state_next = S_SWEEP;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_UPD_LEAF:
            begin
                state_next = S_UPD_ANC;
            end
            S_UPD_ANC:
            begin
                if (node_reg == NODE_W'(1))
                begin
                    state_next = S_RESULT;
                end
            end
            S_WALK:
            begin
                if (node_reg[LEAF_W-1])
                begin
                    state_next = S_WALK_LEAF;
                end
            end
            S_WALK_LEAF:
            begin
                state_next = S_RESULT;
            end
            S_RD_LEAF:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory port and handshake outputs
    always_comb
    begin
        ram_req  = '0;
        in_stall = (state_reg != S_IDLE);
        case (state_reg)
            S_SWEEP:
            begin
                ram_req.wr_en   = s2_vld_reg;
                ram_req.wr_addr = s2_node_reg;
                ram_req.wr_data = s2_sum_reg;
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (op_in == OP_SAMPLE)
                    begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = NODE_W'(2);
                    end
                    else if ((op_in == OP_UPDATE || op_in == OP_READ) && in_ok)
                    begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = {1'b1, leaf_index};
                    end
                end
            end
            S_UPD_LEAF:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = node_reg;
                ram_req.wr_data = SUM_W'(prio_reg);
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = node_reg >> 1;
            end
            S_UPD_ANC:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = node_reg;
                ram_req.wr_data = upd_sum;
                ram_req.rd_en   = (node_reg != NODE_W'(1));
                ram_req.rd_addr = node_reg >> 1;
            end
            S_WALK:
            begin
                ram_req.rd_en   = 1'b1;
                // last inner level reads the leaf itself, otherwise the next left child
                ram_req.rd_addr = node_reg[LEAF_W-1] ? walk_next
                                                     : {walk_next[NODE_W-2:0], 1'b0};
            end
            default:
            begin
                ram_req = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_SWEEP;
            entries_reg      <= CNT_W'(LEAF_COUNT);
            init_prio_reg    <= '0;
            root_reg         <= '0;
            out_valid_reg    <= 1'b0;
            lvl_reg          <= '0;
            off_reg          <= '0;
            sweep_done_reg   <= 1'b0;
            sweep_result_reg <= 1'b0;
            sweep_prio_reg   <= '0;
            s1_vld_reg       <= 1'b0;
            s2_vld_reg       <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            s1_vld_reg <= sweep_issue;
            s2_vld_reg <= s1_vld_reg;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENTRIES: entries_reg   <= cfg_data[CNT_W-1:0];
                    CFG_INIT:    init_prio_reg <= cfg_data[INIT_W-1:0];
                    default:     entries_reg   <= entries_reg;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (in_accept && op_in == OP_FILL)
            begin
                lvl_reg          <= '0;
                off_reg          <= '0;
                sweep_done_reg   <= 1'b0;
                sweep_result_reg <= 1'b1;
                sweep_prio_reg   <= PRIORITY_BITS'(init_prio_reg);
            end
            else if (sweep_issue)
            begin
                if (sweep_last)
                begin
                    sweep_done_reg <= 1'b1;
                end
                else if (off_last)
                begin
                    lvl_reg <= lvl_reg + LVL_W'(1);
                    off_reg <= '0;
                end
                else
                begin
                    off_reg <= off_reg + LEAF_W'(1);
                end
            end

            if (state_reg == S_SWEEP && s2_vld_reg && s2_node_reg == NODE_W'(1))
            begin
                root_reg <= s2_sum_reg;
            end
            else if (state_reg == S_UPD_ANC && node_reg == NODE_W'(1))
            begin
                root_reg <= upd_sum;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        s1_node_reg  <= sweep_node;
        s1_count_reg <= count;
        s2_node_reg  <= s1_node_reg;
        s2_sum_reg   <= product[SUM_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    prio_reg      <= new_priority;
                    val_reg       <= SUM_W'(sample_value);
                    node_reg      <= (op_in == OP_SAMPLE) ? NODE_W'(1) : {1'b1, leaf_index};
                    res_index_reg <= (op_in == OP_FILL) ? '0 : leaf_index;
                    // fill reports its fill value, an in-range update its new priority
                    res_prio_reg  <= (op_in == OP_FILL) ? PRIORITY_BITS'(init_prio_reg)
                                   : (op_in == OP_UPDATE && in_ok) ? new_priority : '0;
                    res_err_reg   <= (op_in != OP_FILL) && !in_ok;
                end
            end
            S_UPD_LEAF:
            begin
                diff_reg <= SUM_W'(prio_reg) - rd_data;
                node_reg <= node_reg >> 1;
            end
            S_UPD_ANC:
            begin
                node_reg <= node_reg >> 1;
            end
            S_WALK:
            begin
                node_reg <= walk_next;
                if (go_right)
                begin
                    val_reg <= val_sub;
                end
            end
            S_WALK_LEAF:
            begin
                res_index_reg <= node_reg[LEAF_W-1:0];
                res_prio_reg  <= rd_data[PRIORITY_BITS-1:0];
                res_err_reg   <= !({1'b0, node_reg[LEAF_W-1:0]} < entries_reg);
            end
            S_RD_LEAF:
            begin
                res_prio_reg <= rd_data[PRIORITY_BITS-1:0];
            end
            default:
            begin
                node_reg <= node_reg;
            end
        endcase

        if (out_load)
        begin
            found_index_reg    <= res_index_reg;
            found_priority_reg <= res_prio_reg;
            total_sum_reg      <= root_reg;
            index_error_reg    <= res_err_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign found_index    = found_index_reg;
    assign found_priority = found_priority_reg;
    assign total_sum      = total_sum_reg;
    assign index_error    = index_error_reg;

endmodule

/* verif/tb.sv */
// self-checking testbench for the priority sum tree: reset-state, directed, backpressure and random tests
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pst_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [LEAF_W-1:0]        idx;
        logic [PRIORITY_BITS-1:0] prio;
        logic [SUM_W-1:0]         total;
        logic                     err;
    } tree_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [OP_W-1:0]          opcode;
    logic [LEAF_W-1:0]        leaf_index;
    logic [PRIORITY_BITS-1:0] new_priority;
    logic [SAMPLE_W-1:0]      sample_value;
    logic                     out_valid;
    logic                     out_stall;
    logic [LEAF_W-1:0]        found_index;
    logic [PRIORITY_BITS-1:0] found_priority;
    logic [SUM_W-1:0]         total_sum;
    logic                     index_error;

    // mirror of the tree and its registers
    logic [63:0]  tree_nodes [1:NODE_DEPTH-1];
    logic [10:0]  entries_reg;
    logic [31:0]  init_prio_reg;

    tree_result_t pending_results [$];
    int           mismatch_count;
    int           idle_cycles;
    int           hold_len;
    bit           tx_quiet;
    bit           rx_quiet;

    priority_sum_tree u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .leaf_index     (leaf_index),
        .new_priority   (new_priority),
        .sample_value   (sample_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .found_index    (found_index),
        .found_priority (found_priority),
        .total_sum      (total_sum),
        .index_error    (index_error)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned live_leaves();
        return (entries_reg > LEAF_COUNT) ? LEAF_COUNT : int'(entries_reg);
    endfunction

    function automatic void rebuild_tree();
        int unsigned lim;
        lim = live_leaves();
        for (int n = 1; n < NODE_DEPTH; n++)
            tree_nodes[n] = '0;
        for (int i = 0; i < lim; i++)
            tree_nodes[LEAF_COUNT + i] = 64'(init_prio_reg);
        for (int n = LEAF_COUNT - 1; n >= 1; n--)
            tree_nodes[n] = tree_nodes[2 * n] + tree_nodes[2 * n + 1];
    endfunction

    // expected result of one request, updating the mirrored tree
    function automatic tree_result_t tree_predict(op_t op, logic [LEAF_W-1:0] leaf,
                                                  logic [PRIORITY_BITS-1:0] prio,
                                                  logic [SAMPLE_W-1:0] sval);
        tree_result_t r;
        int unsigned  n;
        logic [63:0]  rest;
        logic [63:0]  delta;
        bit           in_range;
        r = '0;
        in_range = leaf < live_leaves();
        case (op)
            OP_UPDATE:
            begin
                r.idx = leaf;
                if (in_range)
                begin
                    n = LEAF_COUNT + leaf;
                    delta = 64'(prio) - tree_nodes[n];
                    tree_nodes[n] = 64'(prio);
                    n = n >> 1;
                    while (n >= 1)
                    begin
                        tree_nodes[n] = tree_nodes[n] + delta;
                        n = n >> 1;
                    end
                    r.prio = prio;
                end
                else
                    r.err = 1'b1;
            end
            OP_SAMPLE:
            begin
                rest = 64'(sval);
                n = 1;
                while (n < LEAF_COUNT)
                begin
                    if (rest <= tree_nodes[2 * n])
                        n = 2 * n;
                    else
                    begin
                        rest = rest - tree_nodes[2 * n];
                        n = 2 * n + 1;
                    end
                end
                r.idx  = LEAF_W'(n - LEAF_COUNT);
                r.prio = tree_nodes[n][PRIORITY_BITS-1:0];
                r.err  = (n - LEAF_COUNT) >= live_leaves();
            end
            OP_READ:
            begin
                r.idx = leaf;
                if (in_range)
                    r.prio = tree_nodes[LEAF_COUNT + leaf][PRIORITY_BITS-1:0];
                else
                    r.err = 1'b1;
            end
            default:
            begin
                rebuild_tree();
                r.prio = init_prio_reg;
            end
        endcase
        r.total = tree_nodes[1][SUM_W-1:0];
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ENTRIES)
            entries_reg = data[10:0];
        else
            init_prio_reg = data;
    endtask

    task automatic set_config(int entries, logic [31:0] init_prio);
        write_reg(CFG_ENTRIES, CFG_DATA_W'(entries));
        write_reg(CFG_INIT, init_prio);
    endtask

    task automatic send_req(op_t op, logic [LEAF_W-1:0] leaf, logic [PRIORITY_BITS-1:0] prio,
                            logic [SAMPLE_W-1:0] sval);
        int           gap;
        tree_result_t exp_res;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        opcode       <= op;
        leaf_index   <= leaf;
        new_priority <= prio;
        sample_value <= sval;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        exp_res = tree_predict(op, leaf, prio, sval);
        pending_results = {pending_results, exp_res};
    endtask

    // drop the request and wait until every result is back
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int          r;
        logic [63:0] w;
        logic [63:0] total;
        r = $urandom_range(0, 99);
        w = {$urandom, $urandom};
        total = tree_nodes[1];
        if (r < 10)
            return total[SAMPLE_W-1:0];
        if (r < 14)
            return '0;
        if (r < 28 || total == 0)
            return w[SAMPLE_W-1:0];
        return SAMPLE_W'(w % (total + 1));
    endfunction

    function automatic logic [LEAF_W-1:0] pick_leaf();
        int unsigned lim;
        lim = live_leaves();
        if (lim == 0 || $urandom_range(0, 99) < 12)
            return LEAF_W'($urandom);
        return LEAF_W'($urandom_range(0, lim - 1));
    endfunction

    function automatic logic [PRIORITY_BITS-1:0] pick_prio();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return '1;
        if (r < 40)
            return PRIORITY_BITS'($urandom_range(0, 65535));
        return PRIORITY_BITS'($urandom);
    endfunction

    function automatic void report(string field, logic [63:0] exp_val, logic [63:0] act_val);
        if (exp_val != act_val)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h",
                     $realtime, field, exp_val, act_val);
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        tree_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none actual index %0h total %0h",
                         $realtime, found_index, total_sum);
            end
            else
            begin
                want = pending_results.pop_front();
                report("found_index", 64'(want.idx), 64'(found_index));
                report("found_priority", 64'(want.prio), 64'(found_priority));
                report("total_sum", 64'(want.total), 64'(total_sum));
                report("index_error", 64'(want.err), 64'(index_error));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result side stalls, plus long hold-offs on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                out_stall <= 1'b1;
                hold_len = hold_len - 1;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left = stall_left - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = rx_quiet ? 0 : pick_gap();
            end
        end
    end

    task automatic test_reset_state();
        // the memory clear after reset holds off requests
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        send_req(OP_READ, '0, '0, '0);
        send_req(OP_READ, '1, '1, '1);
        send_req(OP_SAMPLE, '0, '0, '0);
        send_req(OP_SAMPLE, 10'd3, '0, '1);
        send_req(OP_UPDATE, 10'd3, 32'd5, '0);
        wait_idle();
    endtask

    task automatic test_directed_ops();
        set_config(LEAF_COUNT, 32'hFFFF_FFFF);
        send_req(OP_FILL, '0, '0, '0);
        send_req(OP_READ, '0, '0, '0);
        send_req(OP_READ, '1, '0, '0);
        send_req(OP_SAMPLE, '0, '0, '0);
        send_req(OP_SAMPLE, '0, '0, tree_nodes[1][SAMPLE_W-1:0]);
        send_req(OP_SAMPLE, '0, '0, '1);
        send_req(OP_UPDATE, '1, '0, '0);
        send_req(OP_UPDATE, '0, '0, '0);
        send_req(OP_SAMPLE, '0, '0, tree_nodes[1][SAMPLE_W-1:0]);
        wait_idle();

        // few slots in use: index and landing range errors
        set_config(5, 32'h0001_0000);
        send_req(OP_FILL, '0, '0, '0);
        send_req(OP_UPDATE, 10'd5, 32'h1234_5678, '0);
        send_req(OP_READ, 10'd1000, '0, '0);
        send_req(OP_UPDATE, 10'd4, '1, '0);
        send_req(OP_SAMPLE, '0, '0, '1);
        send_req(OP_READ, 10'd4, '0, '0);
        wait_idle();

        // zero slots in use
        set_config(0, 32'h1234_5678);
        send_req(OP_FILL, '0, '0, '0);
        send_req(OP_READ, '0, '0, '0);
        send_req(OP_SAMPLE, '0, '0, '0);
        wait_idle();

        // count above the leaf total acts as the leaf total
        set_config(2047, 32'h0000_0001);
        send_req(OP_FILL, '0, '0, '0);
        send_req(OP_READ, '1, '0, '0);
        send_req(OP_SAMPLE, '0, '0, tree_nodes[1][SAMPLE_W-1:0]);
        wait_idle();
    endtask

    task automatic test_backpressure();
        tx_quiet = 1'b1;
        hold_len = 300;
        for (int i = 0; i < 10; i++)
        begin
            if (i % 2 == 0)
                send_req(OP_UPDATE, pick_leaf(), pick_prio(), '0);
            else
                send_req(OP_SAMPLE, '0, '0, pick_sample());
        end
        tx_quiet = 1'b0;
        wait_idle();
        for (int i = 0; i < 6; i++)
            send_req(OP_READ, pick_leaf(), '0, '0);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int          r;
        int          entries;
        logic [31:0] init_prio;
        for (int phase = 0; phase < 10; phase++)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
                entries = 1;
            else if (r < 22)
                entries = LEAF_COUNT;
            else if (r < 28)
                entries = $urandom_range(LEAF_COUNT + 1, 2047);
            else if (r < 32)
                entries = 0;
            else if (r < 60)
                entries = $urandom_range(2, 16);
            else
                entries = $urandom_range(1, LEAF_COUNT);
            r = $urandom_range(0, 99);
            if (r < 15)
                init_prio = '0;
            else if (r < 30)
                init_prio = '1;
            else
                init_prio = $urandom;
            set_config(entries, init_prio);
            if ($urandom_range(0, 99) < 85)
                send_req(OP_FILL, '0, '0, '0);
            for (int i = 0; i < 140; i++)
            begin
                if (i % 70 == 0)
                begin
                    tx_quiet = ($urandom_range(0, 3) == 0);
                    rx_quiet = ($urandom_range(0, 3) == 0);
                end
                r = $urandom_range(0, 99);
                if (r < 3)
                    send_req(OP_FILL, pick_leaf(), pick_prio(), pick_sample());
                else if (r < 40)
                    send_req(OP_UPDATE, pick_leaf(), pick_prio(), pick_sample());
                else if (r < 78)
                    send_req(OP_SAMPLE, pick_leaf(), pick_prio(), pick_sample());
                else
                    send_req(OP_READ, pick_leaf(), pick_prio(), pick_sample());
            end
            tx_quiet = 1'b0;
            rx_quiet = 1'b0;
            wait_idle();
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        opcode         = '0;
        leaf_index     = '0;
        new_priority   = '0;
        sample_value   = '0;
        mismatch_count = 0;
        idle_cycles    = 0;
        hold_len       = 0;
        tx_quiet       = 1'b0;
        rx_quiet       = 1'b0;
        entries_reg    = 11'(LEAF_COUNT);
        init_prio_reg  = '0;
        for (int n = 1; n < NODE_DEPTH; n++)
            tree_nodes[n] = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_directed_ops();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
